FILE: rtl/vtpd_pkg.sv
`timescale 1ns / 1ps

package vtpd_pkg;

    localparam int NUM_CFG    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int IO_WIDTH   = 32;

    // Register map
    localparam logic [CFG_IDX_W-1:0] REG_ROW0_COLS01 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW0_COLS23 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1_COLS01 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1_COLS23 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2_COLS01 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2_COLS23 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ROW3_COLS01 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ROW3_COLS23 = 3'd7;

    typedef logic [CFG_DATA_W-1:0] t_cfg_word;

    // Identity matrix at reset (1.0 on the diagonal in Q16.16)
    localparam t_cfg_word CFG_RESET [NUM_CFG] = '{
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000
    };

endpackage

FILE: rtl/vertex_transform_persp_divide.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                     Payload
// in        to block   i_in_valid / o_in_ready       i_x_in, i_y_in, i_z_in
// out       from block o_out_valid / i_out_ready     o_x_out, o_y_out, o_z_out,
//                                                    o_w_was_zero, o_saturated
// cfg       to block   i_cfg_we (no wait)            i_cfg_idx, i_cfg_data
//
// One transaction enters per cycle unless the output stalls; the steps are:
// multiply, sum, magnitude, divider setup, one quotient bit per
// stage for COORD_WIDTH + 1 stages, then sign/clamp into the output register.
// The divider sets the latency; throughput is one per clock unless output stalls.
// Reset is synchronous and active low; it clears all valid bits and loads the
// identity matrix. A stall on the output freezes every stage in place.
module vertex_transform_persp_divide #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [vtpd_pkg::IO_WIDTH-1:0] i_x_in,
    input  logic signed [vtpd_pkg::IO_WIDTH-1:0] i_y_in,
    input  logic signed [vtpd_pkg::IO_WIDTH-1:0] i_z_in,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [vtpd_pkg::IO_WIDTH-1:0] o_x_out,
    output logic signed [vtpd_pkg::IO_WIDTH-1:0] o_y_out,
    output logic signed [vtpd_pkg::IO_WIDTH-1:0] o_z_out,
    output logic                                 o_w_was_zero,
    output logic                                 o_saturated,
    input  logic                                 i_cfg_we,
    input  logic [vtpd_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [vtpd_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int W  = COORD_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int PW = 2 * W;              // full product
    localparam int SW = 2 * W - F + 2;      // column sum, signed
    localparam int NW = SW + F;             // scaled dividend magnitude
    localparam int QW = W + 1;              // quotient bits kept
    localparam int RW = NW - QW;            // initial partial remainder
    localparam int CW = (RW > SW) ? RW : SW;

    typedef struct packed {
        logic [2:0][SW-1:0] rem;
        logic [2:0][QW-1:0] quo;
        logic [2:0][QW-1:0] dvd;
        logic [SW-1:0]      dsr;
        logic [2:0]         neg;
        logic [2:0]         ovf;
        logic               wz;
        logic [2:0][W-1:0]  pass;
        logic [2:0]         psat;
    } t_div;

    function automatic logic [SW-1:0] f_abs(input logic signed [SW-1:0] a);
        f_abs = a[SW-1] ? SW'(-a) : a;
    endfunction

    // {sat, value}: saturate a column sum into W bits
    function automatic logic [W:0] f_clamp(input logic signed [SW-1:0] a);
        logic fits;
        fits = (a[SW-1:W-1] == '0) || (a[SW-1:W-1] == '1);
        if (fits) begin
            f_clamp = {1'b0, a[W-1:0]};
        end else begin
            f_clamp = {1'b1, a[SW-1], {(W-1){~a[SW-1]}}};
        end
    endfunction

    vtpd_pkg::t_cfg_word r_cfg [vtpd_pkg::NUM_CFG];

    logic                 en;
    logic signed [W-1:0]  ent [4][4];
    logic signed [W-1:0]  vin [3];

    logic                 r_p_vld;
    logic signed [PW-1:0] r_prod [4][3];
    logic                 r_s_vld;
    logic signed [SW-1:0] r_sum [4];
    logic                 r_m_vld;
    logic [SW-1:0]        r_mag [4];
    logic [2:0]           r_neg;
    logic                 r_wz;
    logic [2:0][W-1:0]    r_pass;
    logic [2:0]           r_psat;

    logic                 r_dv_vld [QW+1];
    t_div                 r_div [QW+1];

    logic [NW-1:0]        s4_num [3];
    logic [RW-1:0]        s4_r0 [3];

    logic                 r_out_vld;
    logic signed [W-1:0]  r_res [3];
    logic                 r_wz_out;
    logic                 r_sat_out;

    // Advance the whole pipe unless a finished result is held; take nothing
    // while reset is applied
    assign en         = !r_out_vld || i_out_ready;
    assign o_in_ready = en && i_rst_n;

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                ent[r][c] = $signed(r_cfg[r * 2 + c / 2][(c % 2) * 32 +: W]);
            end
        end
        vin[0] = $signed(i_x_in[W-1:0]);
        vin[1] = $signed(i_y_in[W-1:0]);
        vin[2] = $signed(i_z_in[W-1:0]);
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < vtpd_pkg::NUM_CFG; i++) begin
                r_cfg[i] <= vtpd_pkg::CFG_RESET[i];
            end
        end else if (i_cfg_we) begin
            r_cfg[i_cfg_idx] <= i_cfg_data;
        end
    end

    // Valid bits of the front stages and output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld      <= 1'b0;
            r_s_vld      <= 1'b0;
            r_m_vld      <= 1'b0;
            r_dv_vld[0]  <= 1'b0;
            r_out_vld    <= 1'b0;
        end else if (en) begin
            r_p_vld      <= i_in_valid;
            r_s_vld      <= r_p_vld;
            r_m_vld      <= r_s_vld;
            r_dv_vld[0]  <= r_m_vld;
            r_out_vld    <= r_dv_vld[QW];
        end
    end

    // Divider setup: split the scaled dividend into first remainder and
    // the bits still to shift in; flag quotients too large for QW bits.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            s4_num[c] = {r_mag[c], {F{1'b0}}};
            s4_r0[c]  = s4_num[c][NW-1:QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // Stage 1: twelve products
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 4; c++) begin
                    r_prod[c][r] <= PW'(vin[r]) * PW'(ent[r][c]);
                end
            end
            // Stage 2: floor to Q format and add translation
            for (int c = 0; c < 4; c++) begin
                r_sum[c] <= SW'(ent[3][c]) + SW'(r_prod[c][0] >>> F)
                          + SW'(r_prod[c][1] >>> F) + SW'(r_prod[c][2] >>> F);
            end
            // Stage 3: magnitudes, signs, undivided fallback
            for (int c = 0; c < 4; c++) begin
                r_mag[c] <= f_abs(r_sum[c]);
            end
            for (int c = 0; c < 3; c++) begin
                r_neg[c]               <= r_sum[c][SW-1] ^ r_sum[3][SW-1];
                {r_psat[c], r_pass[c]} <= f_clamp(r_sum[c]);
            end
            r_wz <= (r_sum[3] == '0);
            // Stage 4
            for (int c = 0; c < 3; c++) begin
                r_div[0].rem[c] <= SW'(s4_r0[c]);
                r_div[0].quo[c] <= '0;
                r_div[0].dvd[c] <= s4_num[c][QW-1:0];
                r_div[0].ovf[c] <= CW'(s4_r0[c]) >= CW'(r_mag[3]);
            end
            r_div[0].dsr  <= r_mag[3];
            r_div[0].neg  <= r_neg;
            r_div[0].wz   <= r_wz;
            r_div[0].pass <= r_pass;
            r_div[0].psat <= r_psat;
        end
    end

    // Restoring division, one quotient bit per stage
    for (genvar k = 1; k <= QW; k++) begin : g_div
        t_div        n_div;
        logic [SW:0] t [3];
        logic [2:0]  ge;

        always_comb begin
            n_div = r_div[k-1];
            for (int c = 0; c < 3; c++) begin
                t[c]  = {r_div[k-1].rem[c], r_div[k-1].dvd[c][QW-1]};
                ge[c] = t[c] >= {1'b0, r_div[k-1].dsr};
                if (ge[c]) begin
                    n_div.rem[c] = SW'(t[c] - {1'b0, r_div[k-1].dsr});
                end else begin
                    n_div.rem[c] = t[c][SW-1:0];
                end
                n_div.quo[c] = {r_div[k-1].quo[c][QW-2:0], ge[c]};
                n_div.dvd[c] = {r_div[k-1].dvd[c][QW-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[k] <= 1'b0;
            end else if (en) begin
                r_dv_vld[k] <= r_dv_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_div[k] <= n_div;
            end
        end
    end

    // Output stage: apply sign, saturate, or take the undivided sums
    always_ff @(posedge i_clk) begin
        logic [2:0]   sat;
        logic [QW-1:0] q;
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                q = r_div[QW].quo[c];
                if (r_div[QW].wz) begin
                    sat[c]   = r_div[QW].psat[c];
                    r_res[c] <= $signed(r_div[QW].pass[c]);
                end else if (r_div[QW].ovf[c]
                             || (!r_div[QW].neg[c] && q[QW-1:W-1] != '0)
                             || (r_div[QW].neg[c] && (q[W] || (q[W-1] && q[W-2:0] != '0)))) begin
                    sat[c]   = 1'b1;
                    r_res[c] <= r_div[QW].neg[c] ? $signed({1'b1, {(W-1){1'b0}}})
                                                 : $signed({1'b0, {(W-1){1'b1}}});
                end else begin
                    sat[c]   = 1'b0;
                    r_res[c] <= r_div[QW].neg[c] ? $signed(W'(~q + 1'b1)) : $signed(q[W-1:0]);
                end
            end
            r_wz_out  <= r_div[QW].wz;
            r_sat_out <= |sat;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_x_out      = vtpd_pkg::IO_WIDTH'(r_res[0]);
    assign o_y_out      = vtpd_pkg::IO_WIDTH'(r_res[1]);
    assign o_z_out      = vtpd_pkg::IO_WIDTH'(r_res[2]);
    assign o_w_was_zero = r_wz_out;
    assign o_saturated  = r_sat_out;

`ifndef SYNTH
    a_rst_clears_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");
    a_stall_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input taken during output stall");
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_p_vld)
        else $error("accepted transaction lost at first stage");
`endif

endmodule
